// ===== rtl/sv32ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// sv32ptw_pkg
// Types and constants shared by the Sv32 page table walker modules.
// ----------------------------------------------------------------------------
package sv32ptw_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [0:0] CMD_TRANSLATE = 1'b0;
  localparam logic [0:0] CMD_PTE_RESP  = 1'b1;

  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;
  localparam logic [1:0] ACC_RSVD  = 2'd3;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_FAULT = 2'd3;

  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_MACHINE = 2'd2;

  localparam logic [2:0] REG_TRANSLATION_ON = 3'd0;
  localparam logic [2:0] REG_ROOT_PPN       = 3'd1;
  localparam logic [2:0] REG_PRIVILEGE      = 3'd2;
  localparam logic [2:0] REG_SUM            = 3'd3;
  localparam logic [2:0] REG_MXR            = 3'd4;

  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_R = 1;
  localparam int unsigned PTE_W = 2;
  localparam int unsigned PTE_X = 3;
  localparam int unsigned PTE_U = 4;
  localparam int unsigned PTE_A = 6;
  localparam int unsigned PTE_D = 7;

  typedef struct packed {
    logic [0:0]  command;
    logic [1:0]  access_type;
    logic [31:0] virtual_address;
    logic [31:0] pc;
    logic [31:0] pte_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [33:0] address;
    logic [31:0] write_data;
    logic [1:0]  fault_type;
    logic [31:0] fault_pc;
    logic [31:0] fault_address;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        translation_on;
    logic [21:0] root_page_number;
    logic [1:0]  privilege;
    logic        supervisor_user_access;
    logic        executable_readable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } walk_res_t;

endpackage

// ===== rtl/sv32ptw_core.sv =====
// ----------------------------------------------------------------------------
// sv32ptw_core
// Walk state and per-transaction translation, permission and update logic.
// ----------------------------------------------------------------------------
module sv32ptw_core import sv32ptw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output walk_res_t res
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] vaddr_r, vaddr_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic [1:0]  acc_r, acc_nxt;
  logic [33:0] ea_r, ea_nxt;

  logic [1:0]  acc_in;
  logic [31:0] pte;
  logic        pte_bad, is_leaf, perm_ok, u_ok, in_walk;
  logic [31:0] upd;
  logic [33:0] phys;
  out_item_t   zero_item, fault_item;

  always_comb begin
    acc_in = (item.access_type == ACC_RSVD) ? ACC_LOAD : item.access_type;
    pte = item.pte_data;
    in_walk = (phase_r == PH_FIRST) || (phase_r == PH_SECOND);
    pte_bad = !pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W]);
    is_leaf = pte[PTE_R] || pte[PTE_X];

    case (cfg.privilege)
      PRIV_USER:  u_ok = pte[PTE_U];
      PRIV_SUPER: u_ok = !pte[PTE_U] ||
                         ((acc_r != ACC_FETCH) && cfg.supervisor_user_access);
      default:    u_ok = 1'b1;
    endcase

    case (acc_r)
      ACC_FETCH: perm_ok = pte[PTE_X];
      ACC_STORE: perm_ok = pte[PTE_W];
      default:   perm_ok = pte[PTE_R] || (cfg.executable_readable && pte[PTE_X]);
    endcase

    upd = pte;
    upd[PTE_A] = 1'b1;
    if (acc_r == ACC_STORE) begin
      upd[PTE_D] = 1'b1;
    end

    if (phase_r == PH_FIRST) begin
      phys = {pte[31:20], vaddr_r[21:0]};
    end else begin
      phys = {pte[31:10], vaddr_r[11:0]};
    end

    zero_item = '0;
    fault_item = '0;
    fault_item.kind = KIND_FAULT;
    fault_item.fault_type = acc_r;
    fault_item.fault_pc = pc_r;
    fault_item.fault_address = vaddr_r;
    fault_item.last = 1'b1;

    phase_nxt = phase_r;
    vaddr_nxt = vaddr_r;
    pc_nxt = pc_r;
    acc_nxt = acc_r;
    ea_nxt = ea_r;
    res.count = 2'd0;
    res.first = zero_item;
    res.second = zero_item;

    if (fire) begin
      if (item.command == CMD_TRANSLATE) begin
        acc_nxt = acc_in;
        vaddr_nxt = item.virtual_address;
        pc_nxt = item.pc;
        res.count = 2'd1;
        res.first.last = 1'b1;
        if (!cfg.translation_on) begin
          phase_nxt = PH_IDLE;
          res.first.kind = KIND_DONE;
          res.first.address = {2'b00, item.virtual_address};
        end else begin
          ea_nxt = {cfg.root_page_number, item.virtual_address[31:22], 2'b00};
          phase_nxt = PH_FIRST;
          res.first.kind = KIND_READ;
          res.first.address = ea_nxt;
        end
      end else if (!in_walk) begin
        phase_nxt = PH_IDLE;
      end else if (pte_bad || (!is_leaf && phase_r == PH_SECOND) ||
                   (is_leaf && (!u_ok || !perm_ok)) ||
                   (is_leaf && phase_r == PH_FIRST && pte[19:10] != 10'd0)) begin
        phase_nxt = PH_IDLE;
        res.count = 2'd1;
        res.first = fault_item;
      end else if (!is_leaf) begin
        ea_nxt = {pte[31:10], vaddr_r[21:12], 2'b00};
        phase_nxt = PH_SECOND;
        res.count = 2'd1;
        res.first.kind = KIND_READ;
        res.first.address = ea_nxt;
        res.first.last = 1'b1;
      end else begin
        phase_nxt = PH_IDLE;
        res.count = 2'd2;
        res.first.kind = KIND_WRITE;
        res.first.address = ea_r;
        res.first.write_data = upd;
        res.second.kind = KIND_DONE;
        res.second.address = phys;
        res.second.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      vaddr_r <= '0;
      pc_r <= '0;
      acc_r <= '0;
      ea_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      vaddr_r <= vaddr_nxt;
      pc_r <= pc_nxt;
      acc_r <= acc_nxt;
      ea_r <= ea_nxt;
    end
  end

endmodule

// ===== rtl/sv32ptw_queue.sv =====
// ----------------------------------------------------------------------------
// sv32ptw_queue
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sv32ptw_queue import sv32ptw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  walk_res_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  out_item_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   tail_r, tail_nxt, tail_plus;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  always_comb begin
    pop = out_valid && out_ready;
    tail_plus = tail_r + PW'(1);
    head_nxt = pop ? head_r + PW'(1) : head_r;
    tail_nxt = tail_r + PW'(push.count);
    count_nxt = count_r + CW'(push.count) - CW'(pop);
  end

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[head_r];
  assign room      = (count_r <= CW'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[tail_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[tail_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/sv32_page_table_walker_top.sv =====
// ----------------------------------------------------------------------------
// sv32_page_table_walker_top
// Sv32 two-level page table walker with permission checks and A/D update.
// ----------------------------------------------------------------------------
// Timing: an accepted input is registered in stage 1, then its results are
//   written into the result queue that drives out_valid; a full queue stalls stage 1.
// Throughput: one input transaction per cycle while the queue has room; a
//   successful leaf gives a write request and then a done result, limited by
//   the one-read result queue port.
// Reset: synchronous rst_n clears the walk, the queue and the registers
//   (privilege resets to machine).
module sv32_page_table_walker_top import sv32ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  cfg_t      cfg_r, cfg_nxt;
  logic      room, advance;
  walk_res_t res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && room;
  assign in_ready  = !s1_valid_r || room;

  always_comb begin
    s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !advance);
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_TRANSLATION_ON: cfg_nxt.translation_on = cfg_data[0];
        REG_ROOT_PPN:       cfg_nxt.root_page_number = cfg_data[21:0];
        REG_PRIVILEGE:      cfg_nxt.privilege = cfg_data[1:0];
        REG_SUM:            cfg_nxt.supervisor_user_access = cfg_data[0];
        REG_MXR:            cfg_nxt.executable_readable = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cfg_r <= '{translation_on: 1'b0, root_page_number: 22'd0,
                 privilege: PRIV_MACHINE, supervisor_user_access: 1'b0,
                 executable_readable: 1'b0};
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  sv32ptw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  sv32ptw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/sv32ptw_checker.sv =====
// ----------------------------------------------------------------------------
// sv32ptw_checker
// Port-level checks on the walker's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sv32ptw_checker import sv32ptw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_WRITE |-> !out_data.last)
    else $error("write request marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.kind == KIND_WRITE |=>
      out_valid && out_data.kind == KIND_DONE && out_data.last)
    else $error("write request not followed by done");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_FAULT |->
      out_data.fault_pc == 32'd0 && out_data.fault_address == 32'd0 &&
      out_data.fault_type == 2'd0)
    else $error("fault fields set on non-fault result");

endmodule

bind sv32_page_table_walker_top sv32ptw_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/sv32_page_table_walker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv32_page_table_walker_top_tb
// Self-checking bench for the Sv32 walker: a directed table of requests,
// entry responses and register writes, then randomised walks over many register
// settings, scored against a bench-side walk predictor or, on some directed rows, fixed results.
// ----------------------------------------------------------------------------
module sv32_page_table_walker_top_tb;
  import sv32ptw_pkg::*;

  localparam logic [1:0] PRIV_RSVD = 2'd3;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 300;

  typedef enum logic [1:0] {LVL_IDLE, LVL_FIRST, LVL_SECOND} walk_level_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] val;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } stim_row_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  cfg_t        ptw_cfg;
  walk_level_t walk_level;
  logic [31:0] held_va;
  logic [31:0] held_pc;
  logic [1:0]  held_acc;
  logic [33:0] pte_addr;

  out_item_t   pending_ptw_results[$];
  stim_row_t   directed_rows[$];
  int          fails     = 0;
  bit          hold_req  = 1'b0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  sv32_page_table_walker_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic out_item_t mk_result(logic [1:0] kind, logic [33:0] addr,
                                          logic [31:0] wdata, logic [1:0] ftype,
                                          logic [31:0] fpc, logic [31:0] fva,
                                          logic last);
    out_item_t r;
    r.kind          = kind;
    r.address       = addr;
    r.write_data    = wdata;
    r.fault_type    = ftype;
    r.fault_pc      = fpc;
    r.fault_address = fva;
    r.last          = last;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 65) return 0;
    if (r < 95) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic bit leaf_permits(logic [31:0] pte);
    logic u;
    u = pte[PTE_U];
    if (ptw_cfg.privilege == PRIV_USER) begin
      if (!u) return 1'b0;
    end else if (ptw_cfg.privilege == PRIV_SUPER) begin
      if (u && (held_acc == ACC_FETCH || !ptw_cfg.supervisor_user_access)) return 1'b0;
    end
    case (held_acc)
      ACC_FETCH: return pte[PTE_X];
      ACC_STORE: return pte[PTE_W];
      default:   return pte[PTE_R] || (ptw_cfg.executable_readable && pte[PTE_X]);
    endcase
  endfunction

  task automatic push_page_fault();
    pending_ptw_results.push_back(mk_result(KIND_FAULT, '0, '0, held_acc, held_pc,
                                            held_va, 1'b1));
    walk_level = LVL_IDLE;
  endtask

  task automatic predict_walk(input in_item_t it);
    logic [31:0] pte;
    logic [31:0] upd;
    logic [33:0] phys;
    if (it.command == CMD_TRANSLATE) begin
      held_acc = (it.access_type == ACC_RSVD) ? ACC_LOAD : it.access_type;
      held_va  = it.virtual_address;
      held_pc  = it.pc;
      if (!ptw_cfg.translation_on) begin
        walk_level = LVL_IDLE;
        pending_ptw_results.push_back(mk_result(KIND_DONE, {2'b00, held_va}, '0, '0, '0,
                                                '0, 1'b1));
      end else begin
        pte_addr   = {ptw_cfg.root_page_number, 12'h000} + {22'h0, held_va[31:22], 2'b00};
        walk_level = LVL_FIRST;
        pending_ptw_results.push_back(mk_result(KIND_READ, pte_addr, '0, '0, '0, '0, 1'b1));
      end
    end else if (walk_level == LVL_IDLE) begin
      walk_level = LVL_IDLE;
    end else begin
      pte = it.pte_data;
      if (!pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W])) begin
        push_page_fault();
      end else if (!(pte[PTE_R] || pte[PTE_X])) begin
        if (walk_level == LVL_SECOND) begin
          push_page_fault();
        end else begin
          pte_addr   = {pte[31:10], 12'h000} + {22'h0, held_va[21:12], 2'b00};
          walk_level = LVL_SECOND;
          pending_ptw_results.push_back(mk_result(KIND_READ, pte_addr, '0, '0, '0, '0,
                                                  1'b1));
        end
      end else if (!leaf_permits(pte)) begin
        push_page_fault();
      end else if (walk_level == LVL_FIRST && pte[19:10] != 10'h000) begin
        push_page_fault();
      end else begin
        phys = (walk_level == LVL_FIRST) ? {pte[31:20], held_va[21:0]}
                                         : {pte[31:10], held_va[11:0]};
        upd = pte;
        upd[PTE_A] = 1'b1;
        if (held_acc == ACC_STORE) upd[PTE_D] = 1'b1;
        walk_level = LVL_IDLE;
        pending_ptw_results.push_back(mk_result(KIND_WRITE, pte_addr, upd, '0, '0, '0, 1'b0));
        pending_ptw_results.push_back(mk_result(KIND_DONE, phys, '0, '0, '0, '0, 1'b1));
      end
    end
  endtask

  function automatic bit field_bad(string name, logic [33:0] w, logic [33:0] g);
    if (g !== w) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, w, g);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    bit bad;
    if (pending_ptw_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      fails++;
    end else begin
      want = pending_ptw_results.pop_front();
      bad  = 1'b0;
      bad |= field_bad("kind", 34'(want.kind), 34'(got.kind));
      bad |= field_bad("address", want.address, got.address);
      bad |= field_bad("write_data", 34'(want.write_data), 34'(got.write_data));
      bad |= field_bad("fault_type", 34'(want.fault_type), 34'(got.fault_type));
      bad |= field_bad("fault_pc", 34'(want.fault_pc), 34'(got.fault_pc));
      bad |= field_bad("fault_address", 34'(want.fault_address), 34'(got.fault_address));
      bad |= field_bad("last", 34'(want.last), 34'(got.last));
      if (bad) fails++;
    end
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_walk(it);
    if (typed) begin
      void'(pending_ptw_results.pop_back());
      pending_ptw_results.push_back(want);
    end
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TRANSLATION_ON: ptw_cfg.translation_on         = val[0];
      REG_ROOT_PPN:       ptw_cfg.root_page_number       = val[21:0];
      REG_PRIVILEGE:      ptw_cfg.privilege              = val[1:0];
      REG_SUM:            ptw_cfg.supervisor_user_access = val[0];
      REG_MXR:            ptw_cfg.executable_readable    = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_ptw_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.command         = 1'($urandom_range(0, 1));
    it.access_type     = 2'($urandom_range(0, 3));
    it.virtual_address = $urandom;
    it.pc              = $urandom;
    it.pte_data        = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] make_pte(walk_level_t lvl);
    logic [31:0] pte;
    bit pointer;
    pte = $urandom;
    if ($urandom_range(0, 9) >= 8) return pte;
    pte[PTE_V] = 1'b1;
    pointer = (lvl == LVL_SECOND) ? ($urandom_range(0, 5) == 0) : 1'($urandom_range(0, 1));
    if (pointer) begin
      pte[3:1] = 3'b000;
    end else begin
      case ($urandom_range(0, 4))
        0: pte[3:1] = 3'b001;
        1: pte[3:1] = 3'b011;
        2: pte[3:1] = 3'b100;
        3: pte[3:1] = 3'b101;
        default: pte[3:1] = 3'b111;
      endcase
      if (lvl == LVL_FIRST && $urandom_range(0, 2) != 0) pte[19:10] = 10'h000;
    end
    if (ptw_cfg.privilege == PRIV_USER) pte[PTE_U] = ($urandom_range(0, 4) != 0);
    return pte;
  endfunction

  task automatic add_req(input logic [1:0] acc, input logic [31:0] va, input logic [31:0] pc);
    stim_row_t r;
    r = '{default: '0};
    r.item.command         = CMD_TRANSLATE;
    r.item.access_type     = acc;
    r.item.virtual_address = va;
    r.item.pc              = pc;
    directed_rows.push_back(r);
  endtask

  task automatic add_resp(input logic [31:0] pte);
    stim_row_t r;
    r = '{default: '0};
    r.item.command  = CMD_PTE_RESP;
    r.item.pte_data = pte;
    directed_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [31:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    directed_rows.push_back(r);
  endtask

  task automatic set_want(input out_item_t w);
    directed_rows[directed_rows.size() - 1].typed = 1'b1;
    directed_rows[directed_rows.size() - 1].want  = w;
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end
    end
  end

  initial begin : stimulus_side
    bit          in_cfg;
    bit          hold_done;
    int          sent;
    int          steps;
    in_item_t    it;
    logic [31:0] v;

    ptw_cfg            = '0;
    ptw_cfg.privilege  = PRIV_MACHINE;
    walk_level         = LVL_IDLE;
    held_va            = '0;
    held_pc            = '0;
    held_acc           = '0;
    pte_addr           = '0;
    in_cfg             = 1'b0;
    hold_done          = 1'b0;

    // pass-through after reset, response while idle
    add_req(ACC_LOAD, 32'hFFFF_FFFF, 32'h0000_0000);
    set_want(mk_result(KIND_DONE, 34'h0_FFFF_FFFF, '0, '0, '0, '0, 1'b1));
    add_req(ACC_FETCH, 32'h0000_0000, 32'hFFFF_FFFF);
    set_want(mk_result(KIND_DONE, 34'h0, '0, '0, '0, '0, 1'b1));
    add_req(ACC_RSVD, 32'h8000_0000, 32'h0000_0004);
    set_want(mk_result(KIND_DONE, 34'h0_8000_0000, '0, '0, '0, '0, 1'b1));
    add_resp(32'hFFFF_FFFF);
    add_cfg(REG_TRANSLATION_ON, 32'h1);
    add_cfg(REG_ROOT_PPN, 32'h003F_FFFF);
    add_cfg(REG_PRIVILEGE, 32'(PRIV_MACHINE));
    add_cfg(REG_SUM, 32'h0);
    add_cfg(REG_MXR, 32'h0);
    add_req(ACC_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_want(mk_result(KIND_READ, 34'h3_FFFF_FFFC, '0, '0, '0, '0, 1'b1));
    add_resp(32'h0000_0000);
    set_want(mk_result(KIND_FAULT, '0, '0, ACC_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    add_req(ACC_LOAD, 32'h0040_1234, 32'h0000_1000);
    add_resp(32'h0000_0005);
    set_want(mk_result(KIND_FAULT, '0, '0, ACC_LOAD, 32'h0000_1000, 32'h0040_1234, 1'b1));
    // two-level walk to a 4 KiB leaf
    add_req(ACC_LOAD, 32'h0040_1234, 32'h0000_1004);
    add_resp(32'h048D_0001);
    add_resp(32'h0020_0003);
    // misaligned and aligned megapages
    add_req(ACC_STORE, 32'hC000_0000, 32'h0000_2000);
    add_resp(32'h0000_040F);
    set_want(mk_result(KIND_FAULT, '0, '0, ACC_STORE, 32'h0000_2000, 32'hC000_0000, 1'b1));
    add_req(ACC_STORE, 32'hC012_3456, 32'h0000_2004);
    add_resp(32'hFFF0_000F);
    // pointer at the second level
    add_req(ACC_FETCH, 32'h1234_5678, 32'h0000_3000);
    add_resp(32'h0000_0401);
    add_resp(32'h0000_0001);
    set_want(mk_result(KIND_FAULT, '0, '0, ACC_FETCH, 32'h0000_3000, 32'h1234_5678, 1'b1));
    // new request abandons the walk in progress
    add_req(ACC_LOAD, 32'h0000_0001, 32'h0000_4000);
    add_req(ACC_FETCH, 32'h0000_0ABC, 32'h0000_4004);
    add_resp(32'h0000_0C01);
    add_resp(32'h0040_0009);
    add_cfg(REG_PRIVILEGE, 32'(PRIV_USER));
    add_req(ACC_LOAD, 32'h0000_0010, 32'h0000_5000);
    add_resp(32'h0000_0003);
    set_want(mk_result(KIND_FAULT, '0, '0, ACC_LOAD, 32'h0000_5000, 32'h0000_0010, 1'b1));
    add_cfg(REG_PRIVILEGE, 32'(PRIV_SUPER));
    add_cfg(REG_MXR, 32'h1);
    add_req(ACC_LOAD, 32'h0000_0020, 32'h0000_6000);
    add_resp(32'h0000_0009);
    add_req(ACC_STORE, 32'h0000_0030, 32'h0000_6004);
    add_resp(32'h0000_0017);
    set_want(mk_result(KIND_FAULT, '0, '0, ACC_STORE, 32'h0000_6004, 32'h0000_0030, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!in_cfg) begin
          wait_drained();
          in_cfg = 1'b1;
        end
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      v = $urandom;
      v[0] = (p == 1) ? 1'b0 : ($urandom_range(0, 7) != 0);
      write_reg(REG_TRANSLATION_ON, v);
      v = $urandom;
      if (p == 0) v[21:0] = 22'h000000;
      if (p == 2) v[21:0] = 22'h3FFFFF;
      write_reg(REG_ROOT_PPN, v);
      v = $urandom;
      if (p == 3) v[1:0] = PRIV_USER;
      if (p == 5) v[1:0] = PRIV_RSVD;
      write_reg(REG_PRIVILEGE, v);
      write_reg(REG_SUM, $urandom);
      write_reg(REG_MXR, $urandom);
      if ($urandom_range(0, 2) == 0) write_reg(REG_MXR + 3'($urandom_range(1, 3)), $urandom);
      cfg_valid <= 1'b0;
      tx_steady = (p % 4 == 3);
      rx_steady = (p % 5 == 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (p == 4 && sent >= 20 && !hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        case ($urandom_range(0, 9))
          0: begin
            send_item(random_item(), 1'b0, '0);
            sent++;
          end
          1: begin
            it = random_item();
            it.command  = CMD_PTE_RESP;
            it.pte_data = make_pte(walk_level);
            send_item(it, 1'b0, '0);
            sent++;
          end
          default: begin
            it = random_item();
            it.command = CMD_TRANSLATE;
            send_item(it, 1'b0, '0);
            sent++;
            steps = 0;
            while (walk_level != LVL_IDLE && steps < 2 && $urandom_range(0, 11) != 0) begin
              it = random_item();
              it.command  = CMD_PTE_RESP;
              it.pte_data = make_pte(walk_level);
              send_item(it, 1'b0, '0);
              sent++;
              steps++;
            end
          end
        endcase
      end
    end

    wait_drained();
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sv32_page_table_walker_top.f =====
rtl/sv32ptw_pkg.sv
rtl/sv32ptw_core.sv
rtl/sv32ptw_queue.sv
rtl/sv32_page_table_walker_top.sv
rtl/sv32ptw_checker.sv
verif/sv32_page_table_walker_top_tb.sv
